FILE: design/btb_pkg.sv
// Shared types and codes for the branch target buffer.
package btb_pkg;

  localparam int BTB_ENTRIES = 16;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_PREDICT = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;

  localparam logic [1:0] KIND_JUMP = 2'd1;
  localparam logic [1:0] KIND_BEQ  = 2'd2;

  localparam logic [1:0] PRED_UNKNOWN   = 2'd0;
  localparam logic [1:0] PRED_NOT_TAKEN = 2'd1;
  localparam logic [1:0] PRED_TAKEN     = 2'd2;

  localparam logic [31:0] PC_STEP = 32'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        pc;
    logic [1:0]         branch_kind;
    logic signed [31:0] imm;
    logic               taken;
  } btb_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  prediction;
  } btb_rsp_t;

  // Command token that walks the row of entry cells, one cell per cycle.
  typedef struct packed {
    logic        active;
    logic        done;
    logic [1:0]  cmd;
    logic [31:0] pc;
    logic        insert_ok;
    logic [31:0] target;
    logic        taken;
    logic [31:0] next_pc;
    logic [1:0]  prediction;
  } btb_tok_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } btb_state_t;

endpackage

FILE: design/btb_cell.sv
// One entry of the buffer together with its stage of the command token chain.
module btb_cell (
  input  logic              clk,
  input  logic              rst,
  input  btb_pkg::btb_tok_t tok_in,
  output btb_pkg::btb_tok_t tok_out
);
  import btb_pkg::*;

  logic        valid;
  logic [31:0] entry_pc;
  logic [31:0] entry_target;
  logic        entry_taken;
  logic        entry_unset;

  logic     live;
  logic     hit;
  logic     wr_new;
  logic     wr_upd;
  btb_tok_t tok_next;

  assign live = tok_in.active && !tok_in.done;
  assign hit  = live && valid && (entry_pc == tok_in.pc);

  always_comb begin
    tok_next = tok_in;
    wr_new   = 1'b0;
    wr_upd   = 1'b0;
    if (live) begin
      case (tok_in.cmd)
        CMD_INSERT: begin
          // Entries fill from the low end and never empty, so the first free
          // cell means the PC is in no later cell either.
          if (hit) begin
            tok_next.done = 1'b1;
          end else if (!valid) begin
            wr_new        = tok_in.insert_ok;
            tok_next.done = 1'b1;
          end
        end
        CMD_PREDICT: begin
          if (hit) begin
            tok_next.done = 1'b1;
            if (entry_taken) begin
              tok_next.next_pc = entry_target;
            end
            if (!entry_unset) begin
              tok_next.prediction = entry_taken ? PRED_TAKEN : PRED_NOT_TAKEN;
            end
          end
        end
        CMD_UPDATE: begin
          if (hit) begin
            tok_next.done = 1'b1;
            wr_upd        = 1'b1;
          end
        end
        default: begin
          tok_next.done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_new) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_new) begin
      entry_pc     <= tok_in.pc;
      entry_target <= tok_in.target;
      entry_taken  <= 1'b0;
      entry_unset  <= 1'b1;
    end else if (wr_upd) begin
      entry_taken <= tok_in.taken;
      entry_unset <= 1'b0;
    end
  end

  // Only the active flag is reset; the rest of the token is plain data.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_next.active;
    end
    tok_out.done       <= tok_next.done;
    tok_out.cmd        <= tok_next.cmd;
    tok_out.pc         <= tok_next.pc;
    tok_out.insert_ok  <= tok_next.insert_ok;
    tok_out.target     <= tok_next.target;
    tok_out.taken      <= tok_next.taken;
    tok_out.next_pc    <= tok_next.next_pc;
    tok_out.prediction <= tok_next.prediction;
  end

endmodule

FILE: design/branch_target_buffer_top.sv
// Fully associative branch target buffer with a one-bit predictor per entry.
// An accepted command becomes a token that walks a row of ENTRIES entry cells,
// one cell per clock, and the response is registered once the token leaves
// the row. A new request is stalled while a token walks the row, so only one
// command is in flight at a time.
// A finished response waits in an output register, and the next request is
// taken in the same cycle that response transfers. Insert, update and unknown
// commands return a response with both fields zero.
module branch_target_buffer_top #(
  parameter int ENTRIES = btb_pkg::BTB_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  btb_pkg::btb_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output btb_pkg::btb_rsp_t rsp
);
  import btb_pkg::*;

  btb_state_t state;
  btb_state_t state_next;
  btb_tok_t   tok [ENTRIES+1];
  logic       accept;
  logic       tok_done;

  assign accept   = req_valid && !req_stall;
  assign tok_done = tok[ENTRIES].active;

  always_comb begin
    tok[0].active     = accept;
    tok[0].done       = 1'b0;
    tok[0].cmd        = req.cmd;
    tok[0].pc         = req.pc;
    tok[0].insert_ok  = (req.branch_kind == KIND_JUMP) || (req.branch_kind == KIND_BEQ);
    tok[0].target     = (req.branch_kind == KIND_JUMP) ? $unsigned(req.imm)
                                                       : req.pc + PC_STEP + $unsigned(req.imm);
    tok[0].taken      = req.taken;
    tok[0].next_pc    = (req.cmd == CMD_PREDICT) ? req.pc + PC_STEP : '0;
    tok[0].prediction = PRED_UNKNOWN;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    btb_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = rsp_valid && rsp_stall;
        if (req_valid && !req_stall) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tok_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Only one token is in flight, and a new one enters only when the output
  // register is empty or transferring, so a finishing token always has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (tok_done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_done) begin
      rsp.next_pc    <= tok[ENTRIES].next_pc;
      rsp.prediction <= tok[ENTRIES].prediction;
    end
  end

endmodule

FILE: tb/branch_target_buffer_top_test.sv
// Self-checking testbench for the branch target buffer: directed table, then random traffic.
module branch_target_buffer_top_test;
  import btb_pkg::*;

  // Codes that the package does not name.
  localparam logic [1:0] CMD_NONE      = 2'd3;
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam int RANDOM_ITEMS = 1575;
  localparam int QUIET_ITEMS  = 200;
  localparam int POOL_SIZE    = 24;

  typedef struct {
    btb_req_t item;
    bit       typed;
    btb_rsp_t want;
  } step_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  btb_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  btb_rsp_t rsp;

  // Shadow copy of the table.
  bit          slot_valid [BTB_ENTRIES];
  logic [31:0] slot_pc    [BTB_ENTRIES];
  logic [31:0] slot_target[BTB_ENTRIES];
  bit          slot_taken [BTB_ENTRIES];
  bit          slot_unset [BTB_ENTRIES];

  btb_rsp_t    awaited_rsp[$];
  step_row_t   plan[$];
  logic [31:0] pc_pool[POOL_SIZE];
  int          mismatches = 0;
  int          hold_left = 0;
  bit          calm = 1'b0;
  bit          quiet = 1'b0;
  btb_rsp_t    head_rsp;

  branch_target_buffer_top #(
    .ENTRIES(BTB_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int hit_slot(input logic [31:0] pc);
    for (int i = 0; i < BTB_ENTRIES; i++) begin
      if (slot_valid[i] && slot_pc[i] == pc) return i;
    end
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < BTB_ENTRIES; i++) begin
      if (!slot_valid[i]) return i;
    end
    return -1;
  endfunction

  // Applies one command to the shadow table and returns the response it yields.
  function automatic btb_rsp_t apply_command(input btb_req_t item);
    btb_rsp_t rsp_want;
    int       slot;
    rsp_want = '0;
    case (item.cmd)
      CMD_INSERT: begin
        if ((item.branch_kind == KIND_JUMP || item.branch_kind == KIND_BEQ) &&
            hit_slot(item.pc) < 0) begin
          slot = free_slot();
          if (slot >= 0) begin
            slot_valid[slot] = 1'b1;
            slot_pc[slot]    = item.pc;
            slot_taken[slot] = 1'b0;
            slot_unset[slot] = 1'b1;
            if (item.branch_kind == KIND_JUMP) slot_target[slot] = item.imm;
            else slot_target[slot] = item.pc + PC_STEP + item.imm;
          end
        end
      end
      CMD_PREDICT: begin
        rsp_want.next_pc    = item.pc + PC_STEP;
        rsp_want.prediction = PRED_UNKNOWN;
        slot = hit_slot(item.pc);
        if (slot >= 0) begin
          if (slot_taken[slot]) rsp_want.next_pc = slot_target[slot];
          if (!slot_unset[slot]) begin
            rsp_want.prediction = slot_taken[slot] ? PRED_TAKEN : PRED_NOT_TAKEN;
          end
        end
      end
      CMD_UPDATE: begin
        slot = hit_slot(item.pc);
        if (slot >= 0) begin
          slot_taken[slot] = item.taken;
          slot_unset[slot] = 1'b0;
        end
      end
      default: ;
    endcase
    return rsp_want;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [31:0] pc,
                         input logic [1:0] kind, input logic [31:0] imm,
                         input logic taken, input bit typed,
                         input logic [31:0] next_pc, input logic [1:0] prediction);
    step_row_t row;
    row.item.cmd          = cmd;
    row.item.pc           = pc;
    row.item.branch_kind  = kind;
    row.item.imm          = imm;
    row.item.taken        = taken;
    row.typed             = typed;
    row.want.next_pc      = next_pc;
    row.want.prediction   = prediction;
    plan.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input btb_req_t item, input bit typed, input btb_rsp_t want);
    btb_rsp_t rsp_want;
    if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    rsp_want = apply_command(item);
    awaited_rsp.push_back(typed ? want : rsp_want);
    @(negedge clk);
  endtask

  function automatic btb_req_t random_item();
    btb_req_t item;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) item.cmd = CMD_INSERT;
    else if (pick < 65) item.cmd = CMD_PREDICT;
    else if (pick < 95) item.cmd = CMD_UPDATE;
    else item.cmd = CMD_NONE;
    item.pc = ($urandom_range(0, 9) == 0) ? $urandom : pc_pool[$urandom_range(0, POOL_SIZE - 1)];
    pick = $urandom_range(0, 9);
    if (pick == 0) item.branch_kind = KIND_NONE;
    else if (pick == 1) item.branch_kind = KIND_RESERVED;
    else if (pick < 6) item.branch_kind = KIND_JUMP;
    else item.branch_kind = KIND_BEQ;
    case ($urandom_range(0, 7))
      0: item.imm = 32'h7FFF_FFFF;
      1: item.imm = 32'h8000_0000;
      2: item.imm = $urandom_range(0, 255) - 128;
      default: item.imm = $urandom;
    endcase
    item.taken = 1'($urandom_range(0, 1));
    return item;
  endfunction

  // Response side holds off in bursts, except in calm stretches and at the end.
  always @(negedge clk) begin
    if (rst || calm || quiet) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      rsp_stall <= 1'b1;
      hold_left = $urandom_range(0, 12);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch($sformatf("response %h/%0d with nothing awaited",
                                  rsp.next_pc, rsp.prediction));
      end else begin
        head_rsp = awaited_rsp.pop_front();
        if (rsp.next_pc !== head_rsp.next_pc) begin
          report_mismatch($sformatf("next_pc %h, expected %h", rsp.next_pc, head_rsp.next_pc));
        end
        if (rsp.prediction !== head_rsp.prediction) begin
          report_mismatch($sformatf("prediction %0d, expected %0d",
                                    rsp.prediction, head_rsp.prediction));
        end
      end
    end
  end

  initial begin
    btb_rsp_t no_rsp;
    no_rsp = '0;
    for (int i = 0; i < BTB_ENTRIES; i++) slot_valid[i] = 1'b0;

    // Empty table, ignored commands, then one entry taken through its states.
    add_row(CMD_PREDICT, 32'h0000_0000, KIND_NONE, 32'h0, 1'b0, 1'b1, 32'h4, PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'hFFFF_FFFC, KIND_NONE, 32'h0, 1'b0, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_UPDATE, 32'h0000_0100, KIND_NONE, 32'h0, 1'b1, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_INSERT, 32'h0000_0100, KIND_NONE, 32'h40, 1'b0, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_INSERT, 32'h0000_0100, KIND_RESERVED, 32'h40, 1'b0, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_NONE, 32'h0000_0100, KIND_RESERVED, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0,
            PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'h0000_0100, KIND_NONE, 32'h0, 1'b0, 1'b1, 32'h104, PRED_UNKNOWN);
    add_row(CMD_INSERT, 32'h0000_0100, KIND_JUMP, 32'h2000, 1'b0, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'h0000_0100, KIND_NONE, 32'h0, 1'b0, 1'b1, 32'h104, PRED_UNKNOWN);
    add_row(CMD_UPDATE, 32'h0000_0100, KIND_NONE, 32'h0, 1'b1, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'h0000_0100, KIND_NONE, 32'h0, 1'b0, 1'b1, 32'h2000, PRED_TAKEN);
    // A second insert of a present PC must not disturb it.
    add_row(CMD_INSERT, 32'h0000_0100, KIND_BEQ, 32'h8, 1'b0, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'h0000_0100, KIND_NONE, 32'h0, 1'b0, 1'b1, 32'h2000, PRED_TAKEN);
    add_row(CMD_UPDATE, 32'h0000_0100, KIND_NONE, 32'h0, 1'b0, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'h0000_0100, KIND_NONE, 32'h0, 1'b0, 1'b1, 32'h104, PRED_NOT_TAKEN);
    // Targets that wrap, with the extremes of the offset.
    add_row(CMD_INSERT, 32'hFFFF_FFFC, KIND_BEQ, 32'h8000_0000, 1'b0, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_UPDATE, 32'hFFFF_FFFC, KIND_NONE, 32'h0, 1'b1, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'hFFFF_FFFC, KIND_NONE, 32'h0, 1'b0, 1'b0, 32'h0, PRED_UNKNOWN);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, KIND_JUMP, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_UPDATE, 32'hFFFF_FFFF, KIND_NONE, 32'h0, 1'b1, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'hFFFF_FFFF, KIND_NONE, 32'h0, 1'b0, 1'b0, 32'h0, PRED_UNKNOWN);
    add_row(CMD_INSERT, 32'h0000_0000, KIND_BEQ, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_UPDATE, 32'h0000_0000, KIND_NONE, 32'h0, 1'b1, 1'b1, 32'h0, PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'h0000_0000, KIND_NONE, 32'h0, 1'b0, 1'b0, 32'h0, PRED_UNKNOWN);
    add_row(CMD_PREDICT, 32'h0000_0101, KIND_NONE, 32'h0, 1'b0, 1'b0, 32'h0, PRED_UNKNOWN);

    pc_pool[0] = 32'h0000_0000;
    pc_pool[1] = 32'hFFFF_FFFC;
    pc_pool[2] = 32'hFFFF_FFFF;
    pc_pool[3] = 32'h8000_0000;
    pc_pool[4] = 32'h0000_0100;
    for (int i = 5; i < POOL_SIZE; i++) pc_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);

    // More PCs than entries, so the table fills and later inserts are dropped.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_item(random_item(), 1'b0, no_rsp);
    end
    req_valid <= 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (2 * BTB_ENTRIES + 4) @(posedge clk);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: branch_target_buffer_top.f
design/btb_pkg.sv
design/btb_cell.sv
design/branch_target_buffer_top.sv
tb/branch_target_buffer_top_test.sv
